### hdl/sfinvsq_pkg.sv
// Shared types, constants and the addition-chain program for the secp256k1
// inverse-squared block. No dependencies.
package sfinvsq_pkg;

  localparam int LIMB_COUNT = 4;
  localparam int LIMB_W     = 64;
  localparam int ELEM_W     = LIMB_COUNT * LIMB_W;
  localparam int DIG_W      = 32;
  localparam int DIG_COUNT  = ELEM_W / DIG_W;

  localparam logic [32:0] CRANDALL_C = 33'h1000003d1;

  // Working register file slots.
  localparam int REG_W = 3;
  localparam logic [REG_W-1:0] REG_X  = 3'd0;
  localparam logic [REG_W-1:0] REG_Z  = 3'd1;
  localparam logic [REG_W-1:0] REG_T0 = 3'd2;
  localparam logic [REG_W-1:0] REG_T1 = 3'd3;
  localparam logic [REG_W-1:0] REG_T2 = 3'd4;
  localparam logic [REG_W-1:0] REG_T3 = 3'd5;

  localparam int STEP_COUNT = 29;
  localparam int STEP_W     = 5;
  localparam int REPS_W     = 7;

  typedef struct packed {
    logic [REG_W-1:0]  dst;
    logic [REG_W-1:0]  src_a;
    logic [REG_W-1:0]  src_b;
    logic [REPS_W-1:0] reps;
  } step_t;

  typedef enum logic [3:0] {
    FM_IDLE, FM_MUL, FM_DRAIN, FM_RED, FM_FOLD, FM_ADD, FM_WRAP, FM_FIX, FM_DONE
  } fmul_state_t;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_LOAD, ST_READ, ST_START, ST_WAIT, ST_WRITE, ST_EMIT_RD, ST_EMIT
  } seq_state_t;

  // First pass of a step multiplies src_a by src_b; further passes square dst.
  function automatic step_t chain_step(input logic [STEP_W-1:0] idx);
    step_t s;
    s = '{REG_Z, REG_X, REG_X, 7'd1};
    unique case (idx)
      5'd0:  s = '{REG_Z,  REG_X,  REG_X,  7'd1};
      5'd1:  s = '{REG_Z,  REG_Z,  REG_X,  7'd1};
      5'd2:  s = '{REG_T0, REG_Z,  REG_Z,  7'd2};
      5'd3:  s = '{REG_T0, REG_T0, REG_Z,  7'd1};
      5'd4:  s = '{REG_T1, REG_T0, REG_T0, 7'd1};
      5'd5:  s = '{REG_T2, REG_T1, REG_X,  7'd1};
      5'd6:  s = '{REG_T1, REG_T2, REG_T2, 7'd2};
      5'd7:  s = '{REG_T1, REG_T1, REG_Z,  7'd1};
      5'd8:  s = '{REG_T3, REG_T1, REG_T1, 7'd4};
      5'd9:  s = '{REG_T0, REG_T0, REG_T3, 7'd1};
      5'd10: s = '{REG_T3, REG_T0, REG_T0, 7'd11};
      5'd11: s = '{REG_T0, REG_T0, REG_T3, 7'd1};
      5'd12: s = '{REG_T3, REG_T0, REG_T0, 7'd5};
      5'd13: s = '{REG_T2, REG_T2, REG_T3, 7'd1};
      5'd14: s = '{REG_T3, REG_T2, REG_T2, 7'd27};
      5'd15: s = '{REG_T2, REG_T2, REG_T3, 7'd1};
      5'd16: s = '{REG_T3, REG_T2, REG_T2, 7'd54};
      5'd17: s = '{REG_T2, REG_T2, REG_T3, 7'd1};
      5'd18: s = '{REG_T3, REG_T2, REG_T2, 7'd108};
      5'd19: s = '{REG_T2, REG_T2, REG_T3, 7'd1};
      5'd20: s = '{REG_T2, REG_T2, REG_T2, 7'd7};
      5'd21: s = '{REG_T1, REG_T1, REG_T2, 7'd1};
      5'd22: s = '{REG_T1, REG_T1, REG_T1, 7'd23};
      5'd23: s = '{REG_T0, REG_T0, REG_T1, 7'd1};
      5'd24: s = '{REG_T0, REG_T0, REG_T0, 7'd5};
      5'd25: s = '{REG_T0, REG_T0, REG_X,  7'd1};
      5'd26: s = '{REG_T0, REG_T0, REG_T0, 7'd3};
      5'd27: s = '{REG_Z,  REG_Z,  REG_T0, 7'd1};
      5'd28: s = '{REG_Z,  REG_Z,  REG_Z,  7'd2};
      default: s = '{REG_Z, REG_X, REG_X, 7'd1};
    endcase
    return s;
  endfunction

endpackage

### hdl/sfinvsq_fmul.sv
// Iterative modular multiplier mod p = 2^256 - 0x1000003d1: column-wise
// 32x32 products, Crandall folding, final correction. Uses sfinvsq_pkg.
module sfinvsq_fmul import sfinvsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ELEM_W-1:0] a,
  input  logic [ELEM_W-1:0] b,
  output logic              done,
  output logic [ELEM_W-1:0] r
);

  fmul_state_t state, state_next;

  logic [3:0]          k;
  logic [2:0]          i;
  logic [2:0]          d;
  logic [63:0]         prod;
  logic                pvalid;
  logic                plast;
  logic [3:0]          pk;
  logic [71:0]         acc;
  logic [2*ELEM_W-1:0] w;
  logic [35:0]         rc;
  logic [68:0]         fm;
  logic [ELEM_W:0]     v;

  logic [2:0]  i_end;
  logic [3:0]  k_inc;
  logic [2:0]  i_start;
  logic [3:0]  j;
  logic [71:0] sum;
  logic [67:0] rsum;
  logic [ELEM_W:0] fix;

  always_comb begin
    i_end   = k[3] ? 3'd7 : k[2:0];
    k_inc   = k + 4'd1;
    i_start = k_inc[3] ? 3'(k_inc - 4'd7) : 3'd0;
    j       = k - {1'b0, i};
    sum     = acc + {8'd0, prod};
    rsum    = {36'd0, w[DIG_W*d +: DIG_W]}
            + {3'd0, 65'(w[ELEM_W + DIG_W*d +: DIG_W] * CRANDALL_C)}
            + {32'd0, rc};
    fix     = {1'b0, v[ELEM_W-1:0]} + {{(ELEM_W-32){1'b0}}, CRANDALL_C};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FM_IDLE:  if (start) state_next = FM_MUL;
      FM_MUL:   if (i == i_end && k == 4'd14) state_next = FM_DRAIN;
      FM_DRAIN: state_next = FM_RED;
      FM_RED:   if (d == 3'd7) state_next = FM_FOLD;
      FM_FOLD:  state_next = FM_ADD;
      FM_ADD:   state_next = FM_WRAP;
      FM_WRAP:  state_next = FM_FIX;
      FM_FIX:   state_next = FM_DONE;
      FM_DONE:  state_next = FM_IDLE;
      default:  state_next = FM_IDLE;
    endcase
  end

  always_comb begin
    done = (state == FM_DONE);
    r    = v[ELEM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FM_IDLE;
      pvalid <= 1'b0;
    end else begin
      state  <= state_next;
      pvalid <= (state == FM_MUL);
    end
  end

  always_ff @(posedge clk) begin
    // issue stage: one 32x32 partial product a cycle, column by column
    if (state == FM_IDLE) begin
      k   <= 4'd0;
      i   <= 3'd0;
      d   <= 3'd0;
      rc  <= '0;
      acc <= '0;
    end
    if (state == FM_MUL) begin
      prod  <= a[DIG_W*i +: DIG_W] * b[DIG_W*j[2:0] +: DIG_W];
      plast <= (i == i_end);
      pk    <= k;
      if (i == i_end) begin
        k <= k_inc;
        i <= i_start;
      end else begin
        i <= i + 3'd1;
      end
    end
    // accumulate stage
    if (pvalid) begin
      if (plast) begin
        w[DIG_W*pk +: DIG_W] <= sum[31:0];
        acc <= sum >> DIG_W;
        if (pk == 4'd14) w[2*ELEM_W-DIG_W +: DIG_W] <= sum[63:32];
      end else begin
        acc <= sum;
      end
    end
    if (state == FM_RED) begin
      v[DIG_W*d +: DIG_W] <= rsum[31:0];
      rc <= rsum[67:32];
      d  <= d + 3'd1;
    end
    if (state == FM_FOLD) fm <= 69'(rc * CRANDALL_C);
    if (state == FM_ADD) v <= {1'b0, v[ELEM_W-1:0]} + {{(ELEM_W-68){1'b0}}, fm};
    // wrap the 2^256 overflow back in as C
    if (state == FM_WRAP && v[ELEM_W]) v <= fix;
    // x >= p exactly when x + C carries out
    if (state == FM_FIX && fix[ELEM_W]) v <= {1'b0, fix[ELEM_W-1:0]};
  end

endmodule

### hdl/secp256k1_field_inverse_squared_top.sv
// Top level: collects four limbs, runs the x^(p-3) addition chain on the
// shared multiplier, returns four limbs. Uses sfinvsq_pkg and sfinvsq_fmul.
//
//  channel | signals                           | direction
//  input   | in_valid, in_stall, limb_value    | request in
//  output  | out_valid, out_stall, result_limb, last_limb | request out
//
// An operand takes four input limbs, then 269 modular products on the one
// multiplier (64 partial products each, then folding, correction and sequencer
// steps), then four output limbs.
// in_stall stays high from the fourth limb until the last result is taken.
// Reset clears the sequencer and limb count; the register file is not cleared.
module secp256k1_field_inverse_squared_top import sfinvsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LIMB_W-1:0] limb_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LIMB_W-1:0] result_limb,
  output logic              last_limb
);

  seq_state_t state, state_next;

  logic [ELEM_W-1:0] regs [2**REG_W];
  logic [ELEM_W-1:0] oper;
  logic [ELEM_W-1:0] opa;
  logic [ELEM_W-1:0] opb;
  logic [1:0]        cnt;
  logic [STEP_W-1:0] step;
  logic [REPS_W-1:0] rep;
  logic              unit_start;
  logic              unit_done;
  logic [ELEM_W-1:0] unit_r;
  step_t             cur;
  logic              in_acc;
  logic              out_acc;
  logic              rep_last;

  sfinvsq_fmul u_fmul (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .a     (opa),
    .b     (opb),
    .done  (unit_done),
    .r     (unit_r)
  );

  always_comb begin
    cur      = chain_step(step);
    in_acc   = in_valid && !in_stall;
    out_acc  = out_valid && !out_stall;
    rep_last = (rep + REPS_W'(1) == cur.reps);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (in_acc && cnt == 2'd3) state_next = ST_LOAD;
      ST_LOAD:    state_next = ST_READ;
      ST_READ:    state_next = ST_START;
      ST_START:   state_next = ST_WAIT;
      ST_WAIT:    if (unit_done) state_next = ST_WRITE;
      ST_WRITE: begin
        if (rep_last && step == STEP_W'(STEP_COUNT - 1)) state_next = ST_EMIT_RD;
        else state_next = ST_READ;
      end
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT:    if (out_acc && cnt == 2'd3) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_COLLECT);
    out_valid   = (state == ST_EMIT);
    unit_start  = (state == ST_START);
    result_limb = opa[LIMB_W*cnt +: LIMB_W];
    last_limb   = (cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      cnt   <= 2'd0;
      step  <= '0;
      rep   <= '0;
    end else begin
      state <= state_next;
      if (in_acc || out_acc) cnt <= cnt + 2'd1;
      if (state == ST_LOAD) begin
        step <= '0;
        rep  <= '0;
      end
      if (state == ST_WRITE) begin
        if (rep_last) begin
          rep  <= '0;
          step <= step + STEP_W'(1);
        end else begin
          rep <= rep + REPS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) oper[LIMB_W*cnt +: LIMB_W] <= limb_value;
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) regs[REG_X] <= oper;
    else if (state == ST_WRITE) regs[cur.dst] <= unit_r;
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      opa <= regs[(rep == '0) ? cur.src_a : cur.dst];
      opb <= regs[(rep == '0) ? cur.src_b : cur.dst];
    end else if (state == ST_EMIT_RD) begin
      opa <= regs[REG_Z];
    end
  end

endmodule

### hdl/sfinvsq_checker.sv
// Port-level checks for the inverse-squared top level, bound to it below.
// Uses sfinvsq_pkg for widths.
module sfinvsq_checker import sfinvsq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [LIMB_W-1:0] result_limb,
  input logic              last_limb
);

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while results pending");

  a_quiet_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result offered right after a request");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_limb) |=> !out_valid)
    else $error("results continue after last limb");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !last_limb) else $error("burst opens on last limb");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_limb)))
    else $error("stalled result changed");

endmodule

bind secp256k1_field_inverse_squared_top sfinvsq_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_limb (result_limb),
  .last_limb   (last_limb)
);

### dv/secp256k1_field_inverse_squared_top_test.sv
// Testbench for secp256k1_field_inverse_squared_top: feeds four-limb operands and
// checks each returned limb against a modular-power predictor (x^(p-3) mod p) or a value given with the operand.
// Depends on sfinvsq_pkg and the top level only.
module secp256k1_field_inverse_squared_top_test;
  import sfinvsq_pkg::*;

  localparam logic [255:0] FIELD_P =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
  localparam logic [63:0] ONES = 64'hFFFFFFFFFFFFFFFF;
  localparam logic [63:0] P_LOW = 64'hFFFFFFFEFFFFFC2F;

  typedef struct {
    logic [LIMB_W-1:0] limb;
    logic              last;
  } limb_out_t;

  typedef struct {
    logic [LIMB_W-1:0] limb;
    bit                typed;
    logic [LIMB_W-1:0] want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [LIMB_W-1:0] limb_value;
  logic              out_valid;
  logic              out_stall;
  logic [LIMB_W-1:0] result_limb;
  logic              last_limb;

  limb_out_t         pending_limbs[$];
  logic [LIMB_W-1:0] operand_store[LIMB_COUNT];
  int                limbs_held;
  int                errs;
  int                sender_idle;
  int                receiver_stall;
  int                hold_left;

  secp256k1_field_inverse_squared_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .limb_value(limb_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_limb(result_limb), .last_limb(last_limb)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Product mod p with two Crandall folds and a final subtract.
  function automatic logic [255:0] mul_mod_p(input logic [255:0] a, input logic [255:0] b);
    logic [511:0] w;
    logic [511:0] t;
    logic [511:0] u;
    w = {256'b0, a} * {256'b0, b};
    t = w[255:0] + w[511:256] * CRANDALL_C;
    u = t[255:0] + t[511:256] * CRANDALL_C;
    while (u >= {256'b0, FIELD_P}) u = u - {256'b0, FIELD_P};
    return u[255:0];
  endfunction

  function automatic logic [255:0] inverse_squared(input logic [255:0] x);
    logic [255:0] e;
    logic [255:0] acc;
    e = FIELD_P - 256'd3;
    if (x >= FIELD_P) x = x - FIELD_P;
    acc = 256'd1;
    for (int i = 255; i >= 0; i--) begin
      acc = mul_mod_p(acc, acc);
      if (e[i]) acc = mul_mod_p(acc, x);
    end
    return acc;
  endfunction

  // Record an accepted limb; on the fourth, queue the four result limbs.
  task automatic record_limb(input stim_row_t row);
    logic [255:0] x;
    logic [255:0] r;
    limb_out_t    e;
    operand_store[limbs_held] = row.limb;
    limbs_held = (limbs_held + 1) % LIMB_COUNT;
    if (limbs_held == 0) begin
      x = {operand_store[3], operand_store[2], operand_store[1], operand_store[0]};
      r = row.typed ? {192'b0, row.want} : inverse_squared(x);
      for (int k = 0; k < LIMB_COUNT; k++) begin
        e.limb = r[k*LIMB_W +: LIMB_W];
        e.last = (k == LIMB_COUNT - 1);
        pending_limbs.push_back(e);
      end
    end
  endtask

  task automatic send_limb(input stim_row_t row);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    limb_value <= row.limb;
    do @(posedge clk); while (in_stall);
    record_limb(row);
  endtask

  task automatic send_operand(input logic [255:0] x);
    stim_row_t row;
    for (int k = 0; k < LIMB_COUNT; k++) begin
      row.limb  = x[k*LIMB_W +: LIMB_W];
      row.typed = 1'b0;
      row.want  = '0;
      send_limb(row);
    end
  endtask

  function automatic logic [255:0] random_operand();
    logic [255:0] x;
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 8; k++) x[k*32 +: 32] = $urandom;
    if (kind == 0) x = {192'b0, x[63:0]} >> $urandom_range(63);
    else if (kind == 1) x = FIELD_P + (x & 256'h3FF_FFFF_FFFF);
    else if (kind == 2) x = FIELD_P - (x & 256'hFFFF);
    return x;
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall);
    end
  end

  always @(posedge clk) begin
    limb_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_limbs.size() == 0) begin
        $error("unexpected result_limb %h", result_limb);
        errs++;
      end else begin
        e = pending_limbs.pop_front();
        if (result_limb !== e.limb) begin
          $error("result_limb: expected %h, got %h", e.limb, result_limb);
          errs++;
        end
        if (last_limb !== e.last) begin
          $error("last_limb: expected %b, got %b", e.last, last_limb);
          errs++;
        end
      end
    end
  end

  initial begin
    #200000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t directed[$];
    // zero, p, all ones (reduced), one, p+1, p-1
    directed = '{
      '{64'd0, 0, 0}, '{64'd0, 0, 0}, '{64'd0, 0, 0}, '{64'd0, 1, 64'd0},
      '{P_LOW, 0, 0}, '{ONES, 0, 0}, '{ONES, 0, 0}, '{ONES, 1, 64'd0},
      '{ONES, 0, 0}, '{ONES, 0, 0}, '{ONES, 0, 0}, '{ONES, 0, 0},
      '{64'd1, 0, 0}, '{64'd0, 0, 0}, '{64'd0, 0, 0}, '{64'd0, 1, 64'd1},
      '{P_LOW + 64'd1, 0, 0}, '{ONES, 0, 0}, '{ONES, 0, 0}, '{ONES, 1, 64'd1},
      '{P_LOW - 64'd1, 0, 0}, '{ONES, 0, 0}, '{ONES, 0, 0}, '{ONES, 1, 64'd1}
    };
    rst            = 1'b1;
    in_valid       = 1'b0;
    limb_value     = '0;
    out_stall      = 1'b0;
    hold_left      = 0;
    limbs_held     = 0;
    errs           = 0;
    sender_idle    = 25;
    receiver_stall = 67;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_limb(directed[i]);
    for (int n = 0; n < 15; n++) send_operand(random_operand());

    sender_idle    = 67;
    receiver_stall = 25;
    for (int n = 0; n < 15; n++) send_operand(random_operand());

    // hold the sender until the block has drained
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_limbs.size() != 0) @(posedge clk);

    sender_idle    = 0;
    receiver_stall = 0;
    @(posedge clk);
    hold_left = 30000;
    for (int n = 0; n < 17; n++) send_operand(random_operand());

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_limbs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### secp256k1_field_inverse_squared_top.f
hdl/sfinvsq_pkg.sv
hdl/sfinvsq_fmul.sv
hdl/secp256k1_field_inverse_squared_top.sv
hdl/sfinvsq_checker.sv
dv/secp256k1_field_inverse_squared_top_test.sv
